/* hdl/nevi_pkg.sv */
// Package for the nearest-edge vertex insert block: shared constants, codes and
// the command and status structures between controller and datapath.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package nevi_pkg;

   localparam int DEF_MAX_VERTICES = 64;
   localparam int DEF_COORD_BITS   = 16;
   localparam int DEF_CNT_W        = $clog2(DEF_MAX_VERTICES + 1);

   localparam int              LIMIT_W     = 34;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 34'd1000000;

   // Function codes of an input item.
   localparam logic [1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [1:0] FUNC_APPEND = 2'd1;
   localparam logic [1:0] FUNC_INSERT = 2'd2;

   // Multiplier operand selections. The same code, registered along with the
   // product, tags it and tells the datapath where the product goes.
   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_EXEX,
      MUL_EYEY,
      MUL_DXEX,
      MUL_DYEY,
      MUL_DXDX,
      MUL_DYDY,
      MUL_FXFX,
      MUL_FYFY,
      MUL_DXEY,
      MUL_DYEX,
      MUL_CRSQ,
      MUL_NHBD,
      MUL_NLBD,
      MUL_BHDN,
      MUL_BLDN
   } mul_sel_type;

   typedef struct packed {
      logic        latch_req;
      logic        clear_count;
      logic        set_full;
      logic        idx_from_count;
      logic        idx_from_found;
      logic        init_scan;
      logic        load_diff;
      mul_sel_type mul_sel;
      logic        select_nd;
      logic        compare;
      logic        next_edge;
      logic        init_shift;
      logic        shift_rd;
      logic        shift_wr;
      logic        write_point;
      logic        load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       count_zero;
      logic       count_full;
      logic       last_edge;
      logic       shift_done;
   } dp_status_type;

endpackage

`default_nettype wire

/* hdl/nevi_if.sv */
// Valid/ready channel interfaces for the request and response items.
// Depends on nevi_pkg for the default count width.
`default_nettype none

interface nevi_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        func;
   logic signed [15:0] point_x;
   logic signed [15:0] point_y;

   modport source (output valid, func, point_x, point_y, input ready);
   modport sink   (input valid, func, point_x, point_y, output ready);
endinterface

interface nevi_rsp_if
   import nevi_pkg::*;
   #(parameter int CNT_W = DEF_CNT_W);
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] insert_index;
   logic [CNT_W-1:0] vertex_total;
   logic             store_full;

   modport source (output valid, insert_index, vertex_total, store_full, input ready);
   modport sink   (input valid, insert_index, vertex_total, store_full, output ready);
endinterface

`default_nettype wire

/* hdl/nevi_datapath.sv */
// Datapath: vertex memory, counters, one shared multiplier with its
// accumulators, the exact distance compare and the response payload.
// Depends on nevi_pkg.
`default_nettype none

module nevi_datapath
   import nevi_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int COORD_BITS   = DEF_COORD_BITS,
   parameter int CNT_W        = $clog2(MAX_VERTICES + 1)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ctl_cmd_type         cmd,
   output dp_status_type            status,
   input  wire logic [1:0]          req_func,
   input  wire logic signed [15:0]  req_x,
   input  wire logic signed [15:0]  req_y,
   input  wire logic                csr_we,
   input  wire logic [LIMIT_W-1:0]  csr_wdata,
   output logic [CNT_W-1:0]         rsp_index,
   output logic [CNT_W-1:0]         rsp_total,
   output logic                     rsp_full
);

   localparam int CB = COORD_BITS;
   localparam int AW = $clog2(MAX_VERTICES);
   localparam int D  = CB + 1;
   localparam int LW = 2 * CB + 1;
   localparam int MW = LW + 1;
   localparam int NW = 2 * LW;
   localparam int CW = 3 * LW;

   logic [2*CB-1:0] vmem [MAX_VERTICES];
   logic [2*CB-1:0] rd_a_ff, rd_b_ff;

   logic [1:0]             func_ff;
   logic signed [CB-1:0]   px_ff, py_ff;
   logic signed [CB-1:0]   px_c, py_c;
   logic [CNT_W-1:0]       count_ff;
   logic [AW-1:0]          idx_ff, i_ff, k_ff, found_ff;
   logic                   full_ff;
   logic [LIMIT_W-1:0]     limit_ff;

   logic signed [D-1:0]    ex_ff, ey_ff, dx_ff, dy_ff, fx_ff, fy_ff;
   logic signed [2*MW-1:0] prod_ff;
   mul_sel_type            tag_ff;
   logic [LW-1:0]          l2_ff, d0_ff, d1_ff;
   logic signed [LW:0]     dot_ff, cr_ff;
   logic [NW-1:0]          crsq_ff, num_ff, bnum_ff;
   logic [LW-1:0]          den_ff, bden_ff;
   logic [CW-1:0]          lhs_ff, rhs_ff;

   logic [CNT_W-1:0]       rsp_index_ff, rsp_total_ff;
   logic                   rsp_full_ff;

   logic [AW-1:0]          nx, addr_a, wr_addr;
   logic                   last_edge, wr_en;
   logic [2*CB-1:0]        wr_data;
   logic signed [CB-1:0]   ax, ay, bx, by;
   logic signed [MW-1:0]   mul_a, mul_b;
   logic [LW:0]            cr_neg;
   logic [LW-1:0]          cr_abs;

   // Wraps or sign-extends the 16-bit input to the stored coordinate width.
   assign px_c = CB'(req_x);
   assign py_c = CB'(req_y);

   assign last_edge = (CNT_W'(i_ff) == count_ff - CNT_W'(1));
   assign nx        = last_edge ? '0 : i_ff + AW'(1);
   assign addr_a    = cmd.shift_rd ? k_ff - AW'(1) : i_ff;

   assign ax = rd_a_ff[2*CB-1:CB];
   assign ay = rd_a_ff[CB-1:0];
   assign bx = rd_b_ff[2*CB-1:CB];
   assign by = rd_b_ff[CB-1:0];

   assign cr_neg = -cr_ff;
   assign cr_abs = cr_ff[LW] ? cr_neg[LW-1:0] : cr_ff[LW-1:0];

   always_comb begin
      wr_en   = cmd.shift_wr | cmd.write_point;
      wr_addr = cmd.shift_wr ? k_ff : idx_ff;
      wr_data = cmd.shift_wr ? rd_a_ff : {px_ff, py_ff};
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         MUL_EXEX: begin mul_a = MW'(ex_ff); mul_b = MW'(ex_ff); end
         MUL_EYEY: begin mul_a = MW'(ey_ff); mul_b = MW'(ey_ff); end
         MUL_DXEX: begin mul_a = MW'(dx_ff); mul_b = MW'(ex_ff); end
         MUL_DYEY: begin mul_a = MW'(dy_ff); mul_b = MW'(ey_ff); end
         MUL_DXDX: begin mul_a = MW'(dx_ff); mul_b = MW'(dx_ff); end
         MUL_DYDY: begin mul_a = MW'(dy_ff); mul_b = MW'(dy_ff); end
         MUL_FXFX: begin mul_a = MW'(fx_ff); mul_b = MW'(fx_ff); end
         MUL_FYFY: begin mul_a = MW'(fy_ff); mul_b = MW'(fy_ff); end
         MUL_DXEY: begin mul_a = MW'(dx_ff); mul_b = MW'(ey_ff); end
         MUL_DYEX: begin mul_a = MW'(dy_ff); mul_b = MW'(ex_ff); end
         MUL_CRSQ: begin
            mul_a = $signed({1'b0, cr_abs});
            mul_b = $signed({1'b0, cr_abs});
         end
         MUL_NHBD: begin
            mul_a = $signed({1'b0, num_ff[NW-1:LW]});
            mul_b = $signed({1'b0, bden_ff});
         end
         MUL_NLBD: begin
            mul_a = $signed({1'b0, num_ff[LW-1:0]});
            mul_b = $signed({1'b0, bden_ff});
         end
         MUL_BHDN: begin
            mul_a = $signed({1'b0, bnum_ff[NW-1:LW]});
            mul_b = $signed({1'b0, den_ff});
         end
         MUL_BLDN: begin
            mul_a = $signed({1'b0, bnum_ff[LW-1:0]});
            mul_b = $signed({1'b0, den_ff});
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   // Vertex memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         vmem[wr_addr] <= wr_data;
      end
      rd_a_ff <= vmem[addr_a];
      rd_b_ff <= vmem[nx];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         limit_ff <= LIMIT_RESET;
         tag_ff   <= MUL_NONE;
      end else begin
         tag_ff <= cmd.mul_sel;
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
         if (cmd.clear_count) begin
            count_ff <= '0;
         end else if (cmd.write_point) begin
            count_ff <= count_ff + CNT_W'(1);
         end
      end
   end

   // Payload and arithmetic registers.
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (cmd.latch_req) begin
         func_ff <= req_func;
         px_ff   <= px_c;
         py_ff   <= py_c;
         idx_ff  <= '0;
         full_ff <= 1'b0;
      end
      if (cmd.set_full)       full_ff <= 1'b1;
      if (cmd.idx_from_count) idx_ff  <= count_ff[AW-1:0];
      if (cmd.idx_from_found) idx_ff  <= found_ff;
      if (cmd.init_shift)     k_ff    <= count_ff[AW-1:0];
      if (cmd.shift_wr)       k_ff    <= k_ff - AW'(1);
      if (cmd.next_edge)      i_ff    <= i_ff + AW'(1);
      if (cmd.init_scan) begin
         i_ff     <= '0;
         found_ff <= '0;
         bnum_ff  <= NW'(limit_ff);
         bden_ff  <= LW'(1);
      end
      if (cmd.load_diff) begin
         ex_ff <= D'(bx) - D'(ax);
         ey_ff <= D'(by) - D'(ay);
         dx_ff <= D'(px_ff) - D'(ax);
         dy_ff <= D'(py_ff) - D'(ay);
         fx_ff <= D'(px_ff) - D'(bx);
         fy_ff <= D'(py_ff) - D'(by);
      end
      case (tag_ff)
         MUL_EXEX: l2_ff   <= prod_ff[LW-1:0];
         MUL_EYEY: l2_ff   <= l2_ff + prod_ff[LW-1:0];
         MUL_DXEX: dot_ff  <= prod_ff[LW:0];
         MUL_DYEY: dot_ff  <= dot_ff + prod_ff[LW:0];
         MUL_DXDX: d0_ff   <= prod_ff[LW-1:0];
         MUL_DYDY: d0_ff   <= d0_ff + prod_ff[LW-1:0];
         MUL_FXFX: d1_ff   <= prod_ff[LW-1:0];
         MUL_FYFY: d1_ff   <= d1_ff + prod_ff[LW-1:0];
         MUL_DXEY: cr_ff   <= prod_ff[LW:0];
         MUL_DYEX: cr_ff   <= cr_ff - prod_ff[LW:0];
         MUL_CRSQ: crsq_ff <= prod_ff[NW-1:0];
         MUL_NHBD: lhs_ff  <= {prod_ff[NW-1:0], LW'(0)};
         MUL_NLBD: lhs_ff  <= lhs_ff + CW'(prod_ff[NW-1:0]);
         MUL_BHDN: rhs_ff  <= {prod_ff[NW-1:0], LW'(0)};
         MUL_BLDN: rhs_ff  <= rhs_ff + CW'(prod_ff[NW-1:0]);
         default: ;
      endcase
      // Endpoint distance when the projection falls off the segment or the
      // segment is degenerate, otherwise the exact fraction cross^2 / len^2.
      if (cmd.select_nd) begin
         if (l2_ff == '0 || dot_ff[LW]) begin
            num_ff <= NW'(d0_ff);
            den_ff <= LW'(1);
         end else if (dot_ff[LW-1:0] > l2_ff) begin
            num_ff <= NW'(d1_ff);
            den_ff <= LW'(1);
         end else begin
            num_ff <= crsq_ff;
            den_ff <= l2_ff;
         end
      end
      if (cmd.compare && (lhs_ff < rhs_ff)) begin
         bnum_ff  <= num_ff;
         bden_ff  <= den_ff;
         found_ff <= nx;
      end
      if (cmd.load_rsp) begin
         rsp_index_ff <= CNT_W'(idx_ff);
         rsp_total_ff <= count_ff;
         rsp_full_ff  <= full_ff;
      end
   end

   always_comb begin
      status.func       = func_ff;
      status.count_zero = (count_ff == '0);
      status.count_full = (count_ff >= CNT_W'(MAX_VERTICES));
      status.last_edge  = last_edge;
      status.shift_done = (k_ff == idx_ff);
   end

   assign rsp_index = rsp_index_ff;
   assign rsp_total = rsp_total_ff;
   assign rsp_full  = rsp_full_ff;

endmodule

`default_nettype wire

/* hdl/nevi_controller.sv */
// Controller state machine: sequences the edge scan, the store shift and the
// response handshake by commands to the datapath. Depends on nevi_pkg.
`default_nettype none

module nevi_controller
   import nevi_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type status,
   output ctl_cmd_type        cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_EDGE,
      S_PLACE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_WRITE,
      S_FINISH
   } state_type;

   localparam logic [4:0] STEP_LAST = 5'd21;

   state_type  state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.mul_sel  = MUL_NONE;
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DECIDE;
            end
         end
         S_DECIDE: begin
            case (status.func)
               FUNC_CLEAR: begin
                  cmd.clear_count = 1'b1;
                  state_in        = S_FINISH;
               end
               FUNC_APPEND: begin
                  if (status.count_full) begin
                     cmd.set_full = 1'b1;
                     state_in     = S_FINISH;
                  end else begin
                     cmd.idx_from_count = 1'b1;
                     cmd.init_shift     = 1'b1;
                     state_in           = S_SHIFT_RD;
                  end
               end
               FUNC_INSERT: begin
                  if (status.count_full) begin
                     cmd.set_full = 1'b1;
                     state_in     = S_FINISH;
                  end else if (status.count_zero) begin
                     cmd.init_shift = 1'b1;
                     state_in       = S_SHIFT_RD;
                  end else begin
                     cmd.init_scan = 1'b1;
                     step_in       = '0;
                     state_in      = S_EDGE;
                  end
               end
               default: state_in = S_FINISH;
            endcase
         end
         S_EDGE: begin
            step_in = step_ff + 5'd1;
            case (step_ff)
               5'd1:  cmd.load_diff = 1'b1;
               5'd2:  cmd.mul_sel = MUL_EXEX;
               5'd3:  cmd.mul_sel = MUL_EYEY;
               5'd4:  cmd.mul_sel = MUL_DXEX;
               5'd5:  cmd.mul_sel = MUL_DYEY;
               5'd6:  cmd.mul_sel = MUL_DXDX;
               5'd7:  cmd.mul_sel = MUL_DYDY;
               5'd8:  cmd.mul_sel = MUL_FXFX;
               5'd9:  cmd.mul_sel = MUL_FYFY;
               5'd10: cmd.mul_sel = MUL_DXEY;
               5'd11: cmd.mul_sel = MUL_DYEX;
               5'd13: cmd.mul_sel = MUL_CRSQ;
               5'd15: cmd.select_nd = 1'b1;
               5'd16: cmd.mul_sel = MUL_NHBD;
               5'd17: cmd.mul_sel = MUL_NLBD;
               5'd18: cmd.mul_sel = MUL_BHDN;
               5'd19: cmd.mul_sel = MUL_BLDN;
               STEP_LAST: begin
                  cmd.compare = 1'b1;
                  step_in     = '0;
                  if (status.last_edge) begin
                     state_in = S_PLACE;
                  end else begin
                     cmd.next_edge = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         S_PLACE: begin
            cmd.idx_from_found = 1'b1;
            cmd.init_shift     = 1'b1;
            state_in           = S_SHIFT_RD;
         end
         S_SHIFT_RD: begin
            if (status.shift_done) begin
               state_in = S_WRITE;
            end else begin
               cmd.shift_rd = 1'b1;
               state_in     = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = S_SHIFT_RD;
         end
         S_WRITE: begin
            cmd.write_point = 1'b1;
            state_in        = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/nearest_edge_vertex_insert.sv */
// Top level of the nearest-edge vertex insert block: ties the controller and
// the datapath to the channels. Depends on nevi_pkg, nevi_if, nevi_controller
// and nevi_datapath.
//
// Use: the block keeps a closed polygon of integer points. Each request item
// carries func, point_x and point_y: func clear empties the polygon, append
// adds the point at the end, insert puts it in the edge nearest to it (exact
// squared point-to-segment distance, first minimum wins, only edges strictly
// below the distance limit qualify). Every request gives exactly one response
// item with the insert position, the vertex total and a full flag. The user
// writes the distance limit via csr_we/csr_wdata only while idle, unchecked.
//
// One item at a time. Clear, refused and unused codes go straight to the
// response; append and an insert into an empty polygon write the point with
// no scan. An insert into N > 0 vertices scans each edge in steps through
// the one shared multiplier; then the store shifts one entry at a time, by a
// read state and a write state. The next item can be accepted in the cycle
// after a result is loaded. Reset empties the polygon and restores the limit
// to 1000000. A result waits in the output register while the receiver
// stalls; a new result is only held back until the previous one is taken.
`default_nettype none

module nearest_edge_vertex_insert
   import nevi_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int COORD_BITS   = DEF_COORD_BITS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   nevi_req_if.sink                req_ch,
   nevi_rsp_if.source              rsp_ch,
   input  wire logic               csr_we,
   input  wire logic [LIMIT_W-1:0] csr_wdata
);

   localparam int CNT_W = $clog2(MAX_VERTICES + 1);

   ctl_cmd_type   cmd;
   dp_status_type status;
   logic          req_ready;
   logic          rsp_valid;
   logic [CNT_W-1:0] rsp_index, rsp_total;
   logic          rsp_full;

   nevi_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   nevi_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_BITS   (COORD_BITS),
      .CNT_W        (CNT_W)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_func  (req_ch.func),
      .req_x     (req_ch.point_x),
      .req_y     (req_ch.point_y),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_index (rsp_index),
      .rsp_total (rsp_total),
      .rsp_full  (rsp_full)
   );

   // The response payload is narrowed or widened to the channel's width.
   assign req_ch.ready        = req_ready;
   assign rsp_ch.valid        = rsp_valid;
   assign rsp_ch.insert_index = rsp_index;
   assign rsp_ch.vertex_total = rsp_total;
   assign rsp_ch.store_full   = rsp_full;

   // Only one item is in work at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request accepted while an item was in work");

   // A refused item is only reported against a full store.
   a_full_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_full |-> rsp_total == CNT_W'(MAX_VERTICES))
      else $error("store full reported below capacity");

   // A placed point always lands inside the stored polygon.
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_index <= rsp_total)
      else $error("insert index beyond vertex total");

endmodule

`default_nettype wire
